[rtl/scplm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scplm_pkg
// Shared types and constants for the starred-character line matcher.
// ----------------------------------------------------------------------------
package scplm_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned REG_SLOTS   = 16;   // positions the char registers hold
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned LEN_W       = 5;
    localparam int unsigned COUNT_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STAR_MASK  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN    = 2'd3;

    // per-beat control broadcast to every cell
    typedef struct packed {
        logic              fresh;   // first item of a line
        logic              load;    // character beat accepted
        logic              clear;   // line end beat accepted
        logic [CHAR_W-1:0] ch;
    } cell_ctl_t;

    // signals one cell hands to the next
    typedef struct packed {
        logic cur_carry;   // current set reaches the next position via a skip
        logic adv;         // character consumed, next position becomes live
        logic ncl_carry;   // next set reaches the next position via a skip
    } cell_link_t;

endpackage

[rtl/scplm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scplm_cell
// One pattern position: live bit, character compare and skip propagation.
// ----------------------------------------------------------------------------
module scplm_cell
    import scplm_pkg::*;
#(
    parameter bit FIRST = 1'b0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctl_t         ctl,
    input  logic [CHAR_W-1:0] pchar,
    input  logic              star,
    input  logic              en,      // position is inside the pattern
    input  logic              keep,    // live bit survives the length mask
    input  cell_link_t        link_in,
    output cell_link_t        link_out,
    output logic              cur
);

    logic live_reg;
    logic live_next;
    logic base;
    logic hit;
    logic nclo;

    always_comb
    begin
        base = ctl.fresh ? FIRST : (live_reg & keep);
        cur  = base | link_in.cur_carry;
        hit  = cur & en & (pchar == ctl.ch);
        nclo = link_in.adv | (hit & star) | link_in.ncl_carry;

        link_out.cur_carry = cur & star & en;
        link_out.adv       = hit;
        link_out.ncl_carry = nclo & star & en;

        live_next = live_reg;
        if (ctl.clear)
        begin
            live_next = 1'b0;
        end
        else if (ctl.load)
        begin
            live_next = nclo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else
        begin
            live_reg <= live_next;
        end
    end

endmodule

[rtl/star_char_pattern_line_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// star_char_pattern_line_match
// Full-line matcher for a literal pattern with per-position Kleene stars.
// ----------------------------------------------------------------------------
// Takes one beat per clock while ready, characters and line ends alike, with
// no bubbles between lines. Each pattern position is a cell holding its live
// bit; the skip closure over starred positions ripples through the cell chain
// in the same cycle as the character compare, so that chain sets the clock
// path. A line end beat yields one result (match flag and saturating match
// count) in the output register on the next cycle; input stays ready while
// that result is taken on the same edge. No clearing pass after reset.
// ----------------------------------------------------------------------------
module star_char_pattern_line_match
    import scplm_pkg::*;
#(
    parameter int unsigned PATTERN_POSITIONS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CHAR_W-1:0]     ch,
    input  logic                  line_end,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  line_matches,
    output logic [COUNT_W-1:0]    matched_line_count,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned CELLS = (PATTERN_POSITIONS < REG_SLOTS) ?
                                    PATTERN_POSITIONS : REG_SLOTS;
    localparam int unsigned LW    = $clog2(CELLS + 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // configuration
    logic [CFG_DATA_W-1:0] chars_low_reg;
    logic [CFG_DATA_W-1:0] chars_high_reg;
    logic [REG_SLOTS-1:0]  star_mask_reg;
    logic [LEN_W-1:0]      pat_len_reg;

    logic                  fresh_reg;
    logic [COUNT_W-1:0]    total_reg;
    logic [COUNT_W-1:0]    total_next;
    logic                  tail_reg;

    logic                  out_valid_reg;
    logic                  match_reg;
    logic [COUNT_W-1:0]    count_reg;

    logic [2*CFG_DATA_W-1:0] chars;
    logic [LW-1:0]           len;
    logic                    accept;
    cell_ctl_t               ctl;
    cell_link_t              links [CELLS+1];
    logic [CELLS:0]          cur_all;
    logic                    tail_base;
    logic                    tail_nclo;
    logic                    hit;

    assign chars    = {chars_high_reg, chars_low_reg};
    assign len      = (pat_len_reg > LEN_W'(CELLS)) ? LW'(CELLS) : pat_len_reg[LW-1:0];
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign ctl.fresh = fresh_reg;
    assign ctl.load  = accept && !line_end;
    assign ctl.clear = accept && line_end;
    assign ctl.ch    = ch;

    assign links[0] = '0;

    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        scplm_cell #(
            .FIRST (k == 0)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .pchar    (chars[CHAR_W*k +: CHAR_W]),
            .star     (star_mask_reg[k]),
            .en       (len > LW'(k)),
            .keep     (len >= LW'(k)),
            .link_in  (links[k]),
            .link_out (links[k+1]),
            .cur      (cur_all[k])
        );
    end

    // final position: whole pattern consumed
    assign tail_base      = !fresh_reg && tail_reg && (len == LW'(CELLS));
    assign cur_all[CELLS] = tail_base | links[CELLS].cur_carry;
    assign tail_nclo      = links[CELLS].adv | links[CELLS].ncl_carry;
    assign hit            = cur_all[len];

    assign total_next = (hit && total_reg != COUNT_MAX) ? total_reg + 1'b1 : total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_low_reg  <= '0;
            chars_high_reg <= '0;
            star_mask_reg  <= '0;
            pat_len_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHARS_LOW:  chars_low_reg  <= cfg_data;
                CFG_CHARS_HIGH: chars_high_reg <= cfg_data;
                CFG_STAR_MASK:  star_mask_reg  <= cfg_data[REG_SLOTS-1:0];
                CFG_PAT_LEN:    pat_len_reg    <= cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg     <= 1'b1;
            tail_reg      <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ctl.load)
            begin
                fresh_reg <= 1'b0;
                tail_reg  <= tail_nclo;
            end
            else if (ctl.clear)
            begin
                fresh_reg <= 1'b1;
                tail_reg  <= 1'b0;
                total_reg <= total_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            match_reg <= hit;
            count_reg <= total_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign line_matches       = match_reg;
    assign matched_line_count = count_reg;

endmodule

[tb/star_char_pattern_line_match_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// star_char_pattern_line_match_test
// Self-checking bench for the starred-character full-line matcher.
// ----------------------------------------------------------------------------
// A bit-vector NFA kept alongside the block predicts the verdict and running
// match count for every line end beat. Directed lines cover reset state,
// literal and starred patterns, the widest and clipped lengths, config
// changes mid-line and a long output stall. Random lines mostly follow the
// configured pattern, some corrupted, some noise.
// ----------------------------------------------------------------------------
module star_char_pattern_line_match_test;
    import scplm_pkg::*;

    localparam int unsigned POSITIONS     = 16;   // min(PATTERN_POSITIONS, REG_SLOTS)
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned RANDOM_PHASES = 6;
    localparam int unsigned PHASE_BEATS   = 50;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] count;
    } line_verdict_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [CHAR_W-1:0]     ch = '0;
    logic                  line_end = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  line_matches;
    logic [COUNT_W-1:0]    matched_line_count;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // shadow of the config registers and the matcher state
    logic [63:0]        pat_lo = '0;
    logic [63:0]        pat_hi = '0;
    logic [15:0]        star_bits = '0;
    logic [LEN_W-1:0]   pat_len = '0;
    logic [16:0]        live_set = '0;
    logic               line_start = 1'b1;
    logic [COUNT_W-1:0] lines_matched = '0;

    line_verdict_t pending_verdicts[$];
    int unsigned   mismatch_count = 0;
    bit            gaps_on = 1'b1;
    int unsigned   burst_left = 0;
    int unsigned   hold_cycles = 0;

    star_char_pattern_line_match dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .ch                 (ch),
        .line_end           (line_end),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .line_matches       (line_matches),
        .matched_line_count (matched_line_count),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int unsigned active_len();
        return (pat_len > POSITIONS) ? POSITIONS : int'(pat_len);
    endfunction

    function automatic logic [CHAR_W-1:0] pos_char(int unsigned k);
        return (k < 8) ? pat_lo[8*k +: 8] : pat_hi[8*(k-8) +: 8];
    endfunction

    // add positions reachable by skipping starred ones
    function automatic logic [16:0] skip_closure(logic [16:0] s, int unsigned n);
        for (int unsigned k = 0; k < n; k++)
        begin
            if (s[k] && star_bits[k])
            begin
                s[k+1] = 1'b1;
            end
        end
        return s;
    endfunction

    function automatic void advance_nfa(logic [CHAR_W-1:0] c, logic is_end);
        int unsigned   n;
        logic [16:0]   keep;
        logic [16:0]   cur;
        logic [16:0]   nxt;
        line_verdict_t verdict;
        n    = active_len();
        keep = 17'((32'h1 << (n + 1)) - 32'h1);
        nxt  = '0;
        cur  = line_start ? skip_closure(17'h1, n) : skip_closure(live_set & keep, n);
        if (is_end)
        begin
            verdict.hit = cur[n];
            if (verdict.hit && lines_matched != '1)
            begin
                lines_matched++;
            end
            verdict.count = lines_matched;
            pending_verdicts.push_back(verdict);
            live_set   = '0;
            line_start = 1'b1;
        end
        else
        begin
            for (int unsigned k = 0; k < n; k++)
            begin
                if (cur[k] && pos_char(k) == c)
                begin
                    nxt[k+1] = 1'b1;
                    if (star_bits[k])
                    begin
                        nxt[k] = 1'b1;
                    end
                end
            end
            live_set   = skip_closure(nxt, n);
            line_start = 1'b0;
        end
    endfunction

    // drive a config write and update the shadow, then drop cfg_we and idle before returning
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CHARS_LOW:  pat_lo = value;
            CFG_CHARS_HIGH: pat_hi = value;
            CFG_STAR_MASK:  star_bits = value[15:0];
            CFG_PAT_LEN:    pat_len = value[LEN_W-1:0];
            default:        ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_pattern(input string s, input logic [15:0] stars,
                                input logic [LEN_W-1:0] n);
        logic [127:0] packed_chars;
        packed_chars = '0;
        for (int i = 0; i < s.len() && i < 16; i++)
        begin
            packed_chars[8*i +: 8] = s[i];
        end
        write_reg(CFG_CHARS_LOW, packed_chars[63:0]);
        write_reg(CFG_CHARS_HIGH, packed_chars[127:64]);
        write_reg(CFG_STAR_MASK, {48'h0, stars});
        write_reg(CFG_PAT_LEN, {59'h0, n});
    endtask

    // one input beat; while gaps_on is set, sender idles in random gaps between bursts
    task automatic send_beat(input logic [CHAR_W-1:0] c, input logic is_end);
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        in_valid <= 1'b1;
        ch       <= c;
        line_end <= is_end;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        advance_nfa(c, is_end);
        if (burst_left > 0)
        begin
            burst_left--;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_beat(s[i], 1'b0);
        end
        send_beat(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // all registers still at reset: empty pattern, only the empty line matches
    task automatic test_reset_state();
        send_text("");
        send_text("x");
    endtask

    task automatic test_literal_pattern();
        drain();
        load_pattern("ab", 16'h0000, 5'd2);
        send_text("ab");
        send_text("abb");
        send_text("a");
        send_text("");
    endtask

    task automatic test_star_skip();
        drain();
        load_pattern("ab", 16'h0001, 5'd2);
        send_text("b");
        send_text("aab");
        send_text("");
    endtask

    // every char 0xFF, every position starred, length beyond the register slots
    task automatic test_full_width_pattern();
        drain();
        write_reg(CFG_CHARS_LOW, '1);
        write_reg(CFG_CHARS_HIGH, '1);
        write_reg(CFG_STAR_MASK, '1);
        write_reg(CFG_PAT_LEN, 64'd31);
        send_text("");
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b1);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
    endtask

    // shrink the length with a line half done; live bits above it are dropped
    task automatic test_midline_config();
        drain();
        load_pattern("ab", 16'h0000, 5'd2);
        send_beat("a", 1'b0);
        send_beat("b", 1'b0);
        drain();
        write_reg(CFG_PAT_LEN, 64'd1);
        send_beat(8'h00, 1'b1);
        drain();
        write_reg(CFG_PAT_LEN, 64'd2);
        send_beat("a", 1'b0);
        drain();
        write_reg(CFG_PAT_LEN, 64'd1);
        send_beat(8'h00, 1'b1);
    endtask

    // receiver holds off while line ends keep coming, so the input stalls
    task automatic test_output_backpressure();
        drain();
        load_pattern("a", 16'h0001, 5'd1);
        gaps_on     = 1'b0;
        hold_cycles = 200;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 3 == 0)
            begin
                send_beat("b", 1'b0);
            end
            send_beat(CHAR_W'($urandom_range(0, 255)), 1'b1);
        end
        gaps_on = 1'b1;
    endtask

    task automatic random_pattern(input int unsigned phase);
        logic [63:0]      lo;
        logic [63:0]      hi;
        logic [63:0]      stars;
        logic [63:0]      n;
        logic [CHAR_W-1:0] b;
        for (int k = 0; k < 16; k++)
        begin
            b = (phase % 2 == 0) ? CHAR_W'(32'h61 + $urandom_range(0, 1))
                                 : CHAR_W'($urandom_range(0, 255));
            if (k < 8)
            begin
                lo[8*k +: 8] = b;
            end
            else
            begin
                hi[8*(k-8) +: 8] = b;
            end
        end
        stars = {$urandom, $urandom};
        n     = {$urandom, $urandom};
        case (phase)
            0:       n[LEN_W-1:0] = 5'd0;
            1:       begin n[LEN_W-1:0] = 5'd16; stars[15:0] = 16'hFFFF; end
            2:       n[LEN_W-1:0] = 5'd31;
            3:       begin n[LEN_W-1:0] = 5'd1; stars[15:0] = 16'h0000; end
            default: n[LEN_W-1:0] = LEN_W'($urandom_range(2, 15));
        endcase
        write_reg(CFG_CHARS_LOW, lo);
        write_reg(CFG_CHARS_HIGH, hi);
        write_reg(CFG_STAR_MASK, stars);
        write_reg(CFG_PAT_LEN, n);
    endtask

    task automatic test_random_lines();
        logic [CHAR_W-1:0] text[$];
        int unsigned       beats;
        int unsigned       n;
        int unsigned       reps;
        logic [CHAR_W-1:0] b;
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain();
            random_pattern(phase);
            n     = active_len();
            beats = 0;
            while (beats < PHASE_BEATS)
            begin
                text.delete();
                if ($urandom_range(0, 9) == 0)
                begin
                    repeat ($urandom_range(0, 6))
                        text.push_back(CHAR_W'($urandom_range(0, 255)));
                end
                else
                begin
                    for (int unsigned k = 0; k < n; k++)
                    begin
                        reps = star_bits[k] ? $urandom_range(0, 3) : 1;
                        repeat (reps) text.push_back(pos_char(k));
                    end
                    if ($urandom_range(0, 3) == 0)
                    begin
                        b = (n > 0 && $urandom_range(0, 1) != 0)
                            ? pos_char($urandom_range(0, n - 1))
                            : CHAR_W'($urandom_range(0, 255));
                        case ($urandom_range(0, 2))
                            0:
                            begin
                                if (text.size() > 0)
                                begin
                                    text[$urandom_range(0, text.size() - 1)] = b;
                                end
                            end
                            1:       text.insert($urandom_range(0, text.size()), b);
                            default:
                            begin
                                if (text.size() > 0)
                                begin
                                    text.delete($urandom_range(0, text.size() - 1));
                                end
                            end
                        endcase
                    end
                end
                foreach (text[i])
                begin
                    send_beat(text[i], 1'b0);
                end
                send_beat(CHAR_W'($urandom_range(0, 255)), 1'b1);
                beats += text.size() + 1;
            end
        end
    endtask

    // receiver: random stall modes, plus a counted hold-off on request
    initial
    begin
        int unsigned mode;
        int unsigned mode_left;
        mode      = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        line_verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("unexpected line result: match=%0b count=%0d",
                             line_matches, matched_line_count);
                end
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (line_matches !== want.hit || matched_line_count !== want.count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("mismatch: want match=%0b count=%0d, got match=%0b count=%0d",
                                 want.hit, want.count, line_matches, matched_line_count);
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_literal_pattern();
        test_star_skip();
        test_full_width_pattern();
        test_midline_config();
        test_output_backpressure();
        test_random_lines();
        drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
